// ===== rtl/assert_macros.svh =====
// Assertion macros used by the deframer engine RTL.
// Depends on nothing; the checks vanish when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CFPD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("deframer assertion failed");
`define CFPD_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("deframer forbidden condition");
`else
`define CFPD_ASSERT(lbl, clk, rstn, prop)
`define CFPD_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ===== rtl/cfpd_pkg.sv =====
// Shared types, constants and the CRC-32 byte step of the deframer.
// Depends on nothing.
package cfpd_pkg;

  localparam int HdrBytes       = 24;
  localparam int MaxPayloadDflt = 64;
  localparam int HdrCrcBytes    = 20;
  localparam int KeepBytes      = 3;
  localparam int QueueDepth     = 2;

  localparam logic [31:0] CrcPoly    = 32'hEDB88320;
  localparam logic [31:0] CrcInit    = 32'hFFFFFFFF;
  localparam logic [15:0] VersionOne = 16'd1;
  localparam logic [15:0] FlagsReset = 16'd3;

  localparam logic [7:0] Magic0 = 8'h41;
  localparam logic [7:0] Magic1 = 8'h50;
  localparam logic [7:0] Magic2 = 8'h50;
  localparam logic [7:0] Magic3 = 8'h31;

  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_LEN   = 3'd1,
    ERR_VER   = 3'd2,
    ERR_FLAGS = 3'd3,
    ERR_HCRC  = 3'd4,
    ERR_PCRC  = 3'd5
  } err_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MSCAN,
    ST_HDR,
    ST_CHK,
    ST_PCRC,
    ST_EMIT,
    ST_EMITW,
    ST_STATUS
  } st_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic        found;
    logic [2:0]  error_code;
    logic [15:0] msg_type;
    logic [31:0] sequence_res;
    logic [15:0] flag_bits;
    logic [6:0]  payload_length;
    logic [7:0]  payload_byte;
    logic [5:0]  byte_index;
    logic        last;
  } result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] t;
    t = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      t = (t >> 1) ^ (t[0] ? CrcPoly : 32'd0);
    end
    return t;
  endfunction

endpackage

// ===== rtl/cfpd_fifo.sv =====
// Small first-in first-out queue used on the input and result sides.
// Depends on nothing but its parameters.
module cfpd_fifo #(
  parameter int W     = 8,
  parameter int Depth = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o,
  output logic         empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [W-1:0]    mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  function automatic logic [PtrW-1:0] inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= inc(wptr_q);
      if (do_pop) rptr_q <= inc(rptr_q);
      if (do_push && !do_pop) cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= wdata_i;
  end

endmodule

// ===== rtl/cfpd_engine.sv =====
// Buffer, resync scan, header and CRC checks and result generation.
// Depends on cfpd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cfpd_engine import cfpd_pkg::*; #(
  parameter int MaxPayload = MaxPayloadDflt
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] allowed_flags_i,
  input  item_t       in_item_i,
  input  logic        in_empty_i,
  output logic        in_pop_o,
  output result_t     out_item_o,
  input  logic        out_full_i,
  output logic        out_push_o
);

  localparam int BufDepth = HdrBytes + MaxPayload;
  localparam int AddrW    = $clog2(BufDepth);
  localparam int CntW     = $clog2(BufDepth + 1);

  st_e state_q, state_d;

  logic [7:0]       mem [BufDepth];
  logic [7:0]       rdata_q;
  logic             re, we;
  logic [AddrW-1:0] ra, wa;

  logic [AddrW-1:0] head_q, head_d;
  logic [CntW-1:0]  count_q, count_d, off_q, off_d, doff_q, doff_d, drop_n;
  logic             dv_q, dv_d, do_drop;
  logic [7:0]       w_q [3];
  logic [31:0]      crc_q, crc_d;
  logic [15:0]      ver_q, type_q, len_q, flags_q;
  logic [31:0]      seq_q, pcrc_q, hcrc_q;
  logic [2:0]       held_q, held_d;
  logic [5:0]       k_q, k_d;

  logic             magic_hit, scan_end, hdr_done, pcrc_done, emit_last;
  logic             short_hdr, len_bad, short_frame;
  logic [2:0]       chk_err;
  logic [CntW-1:0]  pend_end;
  logic [6:0]       nres;

  function automatic logic [AddrW-1:0] wrap_add(input logic [AddrW-1:0] a,
                                                input logic [CntW-1:0] b);
    logic [CntW:0] s;
    s = (CntW+1)'(a) + (CntW+1)'(b);
    if (s >= (CntW+1)'(BufDepth)) s = s - (CntW+1)'(BufDepth);
    return s[AddrW-1:0];
  endfunction

  assign magic_hit = dv_q && (doff_q >= CntW'(3)) && (w_q[2] == Magic0) &&
                     (w_q[1] == Magic1) && (w_q[0] == Magic2) && (rdata_q == Magic3);
  assign scan_end  = !dv_q && (off_q >= count_q);
  assign hdr_done  = dv_q && (doff_q == CntW'(HdrBytes - 1));
  assign pend_end  = CntW'(HdrBytes) + len_q[CntW-1:0];
  assign pcrc_done = !dv_q && (off_q >= pend_end);
  assign short_hdr = count_q < CntW'(HdrBytes);
  assign len_bad   = len_q > 16'(MaxPayload);
  assign short_frame = 17'(count_q) < (17'(HdrBytes) + 17'(len_q));
  assign nres      = (len_q == 16'd0) ? 7'd1 : len_q[6:0];
  assign emit_last = (7'(k_q) + 7'd1) == nres;

  always_comb begin
    if (ver_q != VersionOne) chk_err = ERR_VER;
    else if ((flags_q & ~allowed_flags_i) != 16'd0) chk_err = ERR_FLAGS;
    else if (hcrc_q != ~crc_q) chk_err = ERR_HCRC;
    else chk_err = ERR_NONE;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (!in_empty_i) state_d = ST_MSCAN;
      ST_MSCAN: begin
        if (magic_hit) state_d = ST_HDR;
        else if (scan_end) state_d = ST_STATUS;
      end
      ST_HDR:    if (hdr_done) state_d = ST_CHK;
      ST_CHK: begin
        if (short_hdr) state_d = ST_STATUS;
        else if (len_bad) state_d = ST_MSCAN;
        else if (short_frame) state_d = ST_STATUS;
        else if (chk_err != ERR_NONE) state_d = ST_MSCAN;
        else state_d = ST_PCRC;
      end
      ST_PCRC: begin
        if (pcrc_done) state_d = (pcrc_q == ~crc_q) ? ST_EMIT : ST_MSCAN;
      end
      ST_EMIT:   state_d = ST_EMITW;
      ST_EMITW: begin
        if (!out_full_i) state_d = emit_last ? ST_IDLE : ST_EMIT;
      end
      ST_STATUS: if (!out_full_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    head_d     = head_q;
    count_d    = count_q;
    off_d      = off_q;
    doff_d     = off_q;
    dv_d       = 1'b0;
    crc_d      = crc_q;
    held_d     = held_q;
    k_d        = k_q;
    re         = 1'b0;
    ra         = wrap_add(head_q, off_q);
    we         = 1'b0;
    wa         = wrap_add(head_q, count_q);
    do_drop    = 1'b0;
    drop_n     = '0;
    in_pop_o   = 1'b0;
    out_push_o = 1'b0;
    out_item_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        off_d = '0;
        if (!in_empty_i) begin
          in_pop_o = 1'b1;
          if (!in_item_i.kind && (count_q < CntW'(BufDepth))) begin
            we      = 1'b1;
            count_d = count_q + CntW'(1);
          end
        end
      end
      ST_MSCAN: begin
        if (off_q < count_q) begin
          re    = 1'b1;
          off_d = off_q + CntW'(1);
          dv_d  = 1'b1;
        end
        if (magic_hit) begin
          do_drop = 1'b1;
          drop_n  = doff_q - CntW'(3);
          dv_d    = 1'b0;
          off_d   = '0;
          crc_d   = CrcInit;
        end else if (scan_end && (count_q > CntW'(KeepBytes))) begin
          do_drop = 1'b1;
          drop_n  = count_q - CntW'(KeepBytes);
        end
      end
      ST_HDR: begin
        if (off_q < CntW'(HdrBytes)) begin
          re    = 1'b1;
          off_d = off_q + CntW'(1);
          dv_d  = 1'b1;
        end
        if (dv_q && (doff_q < CntW'(HdrCrcBytes))) crc_d = crc_byte(crc_q, rdata_q);
      end
      ST_CHK: begin
        off_d = '0;
        if (short_hdr) begin
          off_d = '0;
        end else if (len_bad) begin
          held_d  = ERR_LEN;
          do_drop = 1'b1;
          drop_n  = CntW'(1);
        end else if (!short_frame) begin
          if (chk_err != ERR_NONE) begin
            held_d  = chk_err;
            do_drop = 1'b1;
            drop_n  = CntW'(1);
          end else begin
            off_d = CntW'(HdrBytes);
            crc_d = CrcInit;
          end
        end
      end
      ST_PCRC: begin
        if (off_q < pend_end) begin
          re    = 1'b1;
          off_d = off_q + CntW'(1);
          dv_d  = 1'b1;
        end
        if (dv_q) crc_d = crc_byte(crc_q, rdata_q);
        if (pcrc_done) begin
          off_d = '0;
          k_d   = '0;
          if (pcrc_q == ~crc_q) begin
            held_d = ERR_NONE;
          end else begin
            held_d  = ERR_PCRC;
            do_drop = 1'b1;
            drop_n  = CntW'(1);
          end
        end
      end
      ST_EMIT: begin
        re = 1'b1;
        ra = wrap_add(head_q, CntW'(HdrBytes) + CntW'(k_q));
      end
      ST_EMITW: begin
        out_item_o.found          = 1'b1;
        out_item_o.error_code     = ERR_NONE;
        out_item_o.msg_type       = type_q;
        out_item_o.sequence_res   = seq_q;
        out_item_o.flag_bits      = flags_q;
        out_item_o.payload_length = len_q[6:0];
        out_item_o.payload_byte   = (len_q == 16'd0) ? 8'd0 : rdata_q;
        out_item_o.byte_index     = k_q;
        out_item_o.last           = emit_last;
        if (!out_full_i) begin
          out_push_o = 1'b1;
          if (emit_last) begin
            do_drop = 1'b1;
            drop_n  = CntW'(HdrBytes) + len_q[CntW-1:0];
          end else begin
            k_d = k_q + 6'd1;
          end
        end
      end
      ST_STATUS: begin
        out_item_o.error_code = held_q;
        out_item_o.last       = 1'b1;
        out_push_o            = !out_full_i;
      end
      default: begin
        off_d = '0;
      end
    endcase
    if (do_drop) begin
      head_d  = wrap_add(head_q, drop_n);
      count_d = count_q - drop_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      count_q <= '0;
      off_q   <= '0;
      dv_q    <= 1'b0;
      held_q  <= ERR_NONE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      off_q   <= off_d;
      dv_q    <= dv_d;
      held_q  <= held_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    doff_q <= doff_d;
    crc_q  <= crc_d;
    if (dv_q) begin
      w_q[2] <= w_q[1];
      w_q[1] <= w_q[0];
      w_q[0] <= rdata_q;
    end
    if (state_q == ST_HDR && dv_q) begin
      case (doff_q) inside
        CntW'(4), CntW'(5):   ver_q[8*doff_q[0] +: 8] <= rdata_q;
        CntW'(6), CntW'(7):   type_q[8*doff_q[0] +: 8] <= rdata_q;
        [CntW'(8):CntW'(11)]:  seq_q[8*doff_q[1:0] +: 8] <= rdata_q;
        CntW'(12), CntW'(13): len_q[8*doff_q[0] +: 8] <= rdata_q;
        CntW'(14), CntW'(15): flags_q[8*doff_q[0] +: 8] <= rdata_q;
        [CntW'(16):CntW'(19)]: pcrc_q[8*doff_q[1:0] +: 8] <= rdata_q;
        [CntW'(20):CntW'(23)]: hcrc_q[8*doff_q[1:0] +: 8] <= rdata_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= in_item_i.data_byte;
    if (re) rdata_q <= mem[ra];
  end

  `CFPD_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(BufDepth))
  `CFPD_NEVER(a_push_full, clk_i, rst_ni, out_push_o && out_full_i)
  `CFPD_ASSERT(a_pop_idle, clk_i, rst_ni, in_pop_o |-> (state_q == ST_IDLE && !in_empty_i))
  `CFPD_ASSERT(a_head_bound, clk_i, rst_ni, head_q < AddrW'(BufDepth))

endmodule

// ===== rtl/crc_framed_packet_resync_deframer_top.sv =====
// Top level of the magic-word framed packet deframer with CRC-32 checks.
// Depends on cfpd_pkg, cfpd_fifo and cfpd_engine.
//
//   channel   handshake            payload
//   input     push / full          kind_i, data_byte_i
//   result    empty / pop          found_o ... last_o
//   config    psel/penable/pready  paddr, pwdata, prdata
//
// For an accepted frame, one buffer read port serves the magic search, the 24 header
// reads, the payload CRC pass and the result beats, each beat passing through an emit
// read state and an emit wait state. A pass that finds no frame reads every buffered
// byte; each rejected candidate adds a rescan.
// Reset clears the buffer fill, the held error and the queues, not the buffer itself.
// A full result queue stalls the back part while the input queue keeps accepting beats until it fills.
module crc_framed_packet_resync_deframer_top import cfpd_pkg::*; #(
  parameter int MaxPayload = MaxPayloadDflt
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic        found_o,
  output logic [2:0]  error_code_o,
  output logic [15:0] msg_type_o,
  output logic [31:0] sequence_res_o,
  output logic [15:0] flag_bits_o,
  output logic [6:0]  payload_length_o,
  output logic [7:0]  payload_byte_o,
  output logic [5:0]  byte_index_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] allowed_q;
  item_t       in_w, in_r;
  result_t     res_w, res_r;
  logic        in_empty, in_pop, res_full, res_push;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {16'd0, allowed_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allowed_q <= FlagsReset;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      allowed_q <= pwdata[15:0];
    end
  end

  assign in_w.kind      = kind_i;
  assign in_w.data_byte = data_byte_i;

  cfpd_fifo #(.W($bits(item_t)), .Depth(QueueDepth)) u_in_q (
    .clk_i, .rst_ni,
    .push_i(push), .wdata_i(in_w), .full_o(full),
    .pop_i(in_pop), .rdata_o(in_r), .empty_o(in_empty)
  );

  cfpd_engine #(.MaxPayload(MaxPayload)) u_engine (
    .clk_i, .rst_ni,
    .allowed_flags_i(allowed_q),
    .in_item_i(in_r), .in_empty_i(in_empty), .in_pop_o(in_pop),
    .out_item_o(res_w), .out_full_i(res_full), .out_push_o(res_push)
  );

  cfpd_fifo #(.W($bits(result_t)), .Depth(QueueDepth)) u_res_q (
    .clk_i, .rst_ni,
    .push_i(res_push), .wdata_i(res_w), .full_o(res_full),
    .pop_i(pop), .rdata_o(res_r), .empty_o(empty)
  );

  assign found_o          = res_r.found;
  assign error_code_o     = res_r.error_code;
  assign msg_type_o       = res_r.msg_type;
  assign sequence_res_o   = res_r.sequence_res;
  assign flag_bits_o      = res_r.flag_bits;
  assign payload_length_o = res_r.payload_length;
  assign payload_byte_o   = res_r.payload_byte;
  assign byte_index_o     = res_r.byte_index;
  assign last_o           = res_r.last;

endmodule
